FILE: design/lpca_pkg.sv
// Types, constants and divider step shared by the line-pair closest-approach block.
package lpca_pkg;

	localparam int PosW  = 24;
	localparam int DirW  = 16;
	localparam int ThrW  = 29;
	localparam int SumW  = 25;
	localparam int QBits = 41;
	localparam int DenW  = 57;
	localparam int RemW  = 58;
	localparam int MagW  = 70;
	localparam int NumW  = 72;
	localparam int ParW  = 42;
	localparam int PipeLat = QBits + 10;

	localparam logic [ThrW-1:0] ThrReset = 29'd32;
	localparam logic [QBits-1:0] ParLimit = 41'h100_0000_0000;

	typedef struct packed {
		logic signed [PosW-1:0] first_point_x;
		logic signed [PosW-1:0] first_point_y;
		logic signed [PosW-1:0] first_point_z;
		logic signed [DirW-1:0] first_dir_x;
		logic signed [DirW-1:0] first_dir_y;
		logic signed [DirW-1:0] first_dir_z;
		logic signed [PosW-1:0] second_point_x;
		logic signed [PosW-1:0] second_point_y;
		logic signed [PosW-1:0] second_point_z;
		logic signed [DirW-1:0] second_dir_x;
		logic signed [DirW-1:0] second_dir_y;
		logic signed [DirW-1:0] second_dir_z;
	} item_t;

	typedef struct packed {
		logic signed [PosW-1:0] mid_x;
		logic signed [PosW-1:0] mid_y;
		logic signed [PosW-1:0] mid_z;
		logic                   in_front;
		logic                   parallel_error;
	} result_t;

	// point sums and directions carried down the pipe
	typedef struct packed {
		logic signed [SumW-1:0] ab_x;
		logic signed [SumW-1:0] ab_y;
		logic signed [SumW-1:0] ab_z;
		logic signed [DirW-1:0] ux;
		logic signed [DirW-1:0] uy;
		logic signed [DirW-1:0] uz;
		logic signed [DirW-1:0] vx;
		logic signed [DirW-1:0] vy;
		logic signed [DirW-1:0] vz;
	} pay_t;

	// state of one restoring division
	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [QBits-1:0] low;
		logic [QBits-1:0] quo;
		logic             ovf;
		logic             neg;
	} div_t;

	typedef struct packed {
		pay_t            pay;
		logic            par;
		logic [DenW-1:0] den;
		div_t            dp;
		div_t            dq;
	} carry_t;

	// one quotient bit of a restoring division
	function automatic div_t div_step(div_t d, logic [DenW-1:0] den);
		div_t r;
		logic [RemW-1:0] trial;
		r = d;
		trial = {d.rem[RemW-2:0], d.low[QBits-1]};
		r.low = {d.low[QBits-2:0], 1'b0};
		if (trial >= {1'b0, den}) begin
			r.rem = trial - {1'b0, den};
			r.quo = {d.quo[QBits-2:0], 1'b1};
		end else begin
			r.rem = trial;
			r.quo = {d.quo[QBits-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic carry_t carry_step(carry_t c);
		carry_t r;
		r = c;
		r.dp = div_step(c.dp, c.den);
		r.dq = div_step(c.dq, c.den);
		return r;
	endfunction

	// saturate a finished quotient and apply its sign
	function automatic logic signed [ParW-1:0] param_value(div_t d);
		logic [QBits-1:0] m;
		logic signed [ParW-1:0] s;
		m = (d.ovf || d.quo > ParLimit) ? ParLimit : d.quo;
		s = $signed({1'b0, m});
		return d.neg ? -s : s;
	endfunction

endpackage

FILE: design/line_pair_closest_approach.sv
// Top level: pipelined closest approach of two 3D lines.
//
// Usage: present a line pair on item and raise start for one cycle; the
// transaction is taken at that edge. busy is always low, so a new pair may
// enter on every clock. Each pair yields exactly one result on result, marked
// by done for one cycle. Throughput is one pair per cycle. The latency is set
// by the two parallel restoring dividers for P and Q, which form one quotient
// bit per stage over 41 stages, plus seven stages of products and sums and one
// divider entry stage ahead of them and three stages of saturation, midpoint
// products and rounding behind them.
// The receiver cannot stall: a result is on the ports for one cycle only.
// cfg_we/cfg_data write the parallel threshold (Q1.28); write it while no
// transaction is in flight. Reset clears all valid bits, dropping any pair in
// flight, and loads the threshold with 32.
module line_pair_closest_approach (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lpca_pkg::item_t               item,
	output logic                          done,
	output lpca_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [lpca_pkg::ThrW-1:0]     cfg_data
);

	logic [lpca_pkg::ThrW-1:0] thr_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_sp, vld_sm, done_q;
	logic [lpca_pkg::QBits:0] vld_dv;

	lpca_pkg::pay_t pay_s1, pay_s2, pay_s3, pay_s4, pay_s5, pay_s6, pay_s7, pay_sp;
	lpca_pkg::carry_t car_s [lpca_pkg::QBits+1];

	logic signed [lpca_pkg::SumW-1:0] d_s1 [3];
	logic signed [31:0] uv_s2 [3];
	logic signed [40:0] ud_s2 [3];
	logic signed [40:0] vd_s2 [3];
	logic signed [33:0] c_s3;
	logic signed [42:0] ud_s3, vd_s3;
	logic signed [28:0] c_s4;
	logic [28:0] om_s4, opl_s4;
	logic signed [42:0] ud_s4, vd_s4;
	logic par_s4, par_s5, par_s6, par_s7;
	logic [lpca_pkg::DenW-1:0] den_s5, den_s6, den_s7;
	logic signed [50:0] cudh_s5, cudl_s5, cvdh_s5, cvdl_s5;
	logic signed [42:0] ud_s5, vd_s5;
	logic signed [lpca_pkg::NumW-1:0] np_s6, nq_s6;
	logic [lpca_pkg::MagW-1:0] mp_s7, mq_s7;
	logic negp_s7, negq_s7;
	logic signed [lpca_pkg::ParW-1:0] p_sp, q_sp;
	logic par_sp, front_sp, par_sm, front_sm;
	logic signed [57:0] mu_sm [3];
	logic signed [57:0] mv_sm [3];
	logic signed [38:0] ab_sm [3];
	lpca_pkg::result_t result_q;

	// no back-pressure: a transaction enters on every start
	assign busy = 1'b0;

	// hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= lpca_pkg::ThrReset;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
			vld_dv <= '0;
			vld_sp <= 1'b0; vld_sm <= 1'b0; done_q <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
			vld_dv <= {vld_dv[lpca_pkg::QBits-1:0], vld_s7};
			vld_sp <= vld_dv[lpca_pkg::QBits];
			vld_sm <= vld_sp;
			done_q <= vld_sm;
		end
	end

	// stage 1: point sums and differences
	logic signed [lpca_pkg::PosW-1:0] pa [3];
	logic signed [lpca_pkg::PosW-1:0] pb [3];
	always_comb begin
		pa[0] = item.first_point_x;  pa[1] = item.first_point_y;  pa[2] = item.first_point_z;
		pb[0] = item.second_point_x; pb[1] = item.second_point_y; pb[2] = item.second_point_z;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i] <= 25'(pb[i]) - 25'(pa[i]);
		end
		pay_s1.ab_x <= 25'(pa[0]) + 25'(pb[0]);
		pay_s1.ab_y <= 25'(pa[1]) + 25'(pb[1]);
		pay_s1.ab_z <= 25'(pa[2]) + 25'(pb[2]);
		pay_s1.ux <= item.first_dir_x;  pay_s1.uy <= item.first_dir_y;
		pay_s1.uz <= item.first_dir_z;
		pay_s1.vx <= item.second_dir_x; pay_s1.vy <= item.second_dir_y;
		pay_s1.vz <= item.second_dir_z;
	end

	// stage 2: per-axis products
	logic signed [lpca_pkg::DirW-1:0] u1 [3];
	logic signed [lpca_pkg::DirW-1:0] v1 [3];
	always_comb begin
		u1[0] = pay_s1.ux; u1[1] = pay_s1.uy; u1[2] = pay_s1.uz;
		v1[0] = pay_s1.vx; v1[1] = pay_s1.vy; v1[2] = pay_s1.vz;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			uv_s2[i] <= 32'(u1[i]) * 32'(v1[i]);
			ud_s2[i] <= 41'(u1[i]) * 41'(d_s1[i]);
			vd_s2[i] <= 41'(v1[i]) * 41'(d_s1[i]);
		end
		pay_s2 <= pay_s1;
	end

	// stage 3: dot products
	always_ff @(posedge clk) begin
		c_s3  <= 34'(uv_s2[0]) + 34'(uv_s2[1]) + 34'(uv_s2[2]);
		ud_s3 <= 43'(ud_s2[0]) + 43'(ud_s2[1]) + 43'(ud_s2[2]);
		vd_s3 <= 43'(vd_s2[0]) + 43'(vd_s2[1]) + 43'(vd_s2[2]);
		pay_s3 <= pay_s2;
	end

	// stage 4: parallel test and denominator factors
	logic signed [33:0] ac3;
	logic signed [34:0] om3, opl3;
	logic om_le0;
	always_comb begin
		ac3  = c_s3[33] ? -c_s3 : c_s3;
		om3  = 35'sd268435456 - 35'(ac3);
		opl3 = 35'sd268435456 + 35'(ac3);
		om_le0 = om3[34] | (om3 == 35'sd0);
	end

	always_ff @(posedge clk) begin
		par_s4 <= om_le0 || (om3[28:0] < thr_q);
		om_s4  <= om3[28:0];
		opl_s4 <= opl3[28:0];
		c_s4   <= c_s3[28:0];
		ud_s4  <= ud_s3;
		vd_s4  <= vd_s3;
		pay_s4 <= pay_s3;
	end

	// stage 5: denominator and split cross products
	logic [57:0] den_full;
	always_comb begin
		den_full = 58'(om_s4) * 58'(opl_s4);
	end

	always_ff @(posedge clk) begin
		den_s5  <= den_full[lpca_pkg::DenW-1:0];
		cudh_s5 <= 51'(c_s4) * 51'($signed(ud_s4[42:21]));
		cudl_s5 <= 51'(c_s4) * 51'($signed({1'b0, ud_s4[20:0]}));
		cvdh_s5 <= 51'(c_s4) * 51'($signed(vd_s4[42:21]));
		cvdl_s5 <= 51'(c_s4) * 51'($signed({1'b0, vd_s4[20:0]}));
		ud_s5   <= ud_s4;
		vd_s5   <= vd_s4;
		par_s5  <= par_s4;
		pay_s5  <= pay_s4;
	end

	// stage 6: numerators
	always_ff @(posedge clk) begin
		np_s6 <= (72'(ud_s5) <<< 28) - ((72'(cvdh_s5) <<< 21) + 72'(cvdl_s5));
		nq_s6 <= ((72'(cudh_s5) <<< 21) + 72'(cudl_s5)) - (72'(vd_s5) <<< 28);
		den_s6 <= den_s5;
		par_s6 <= par_s5;
		pay_s6 <= pay_s5;
	end

	// stage 7: numerator magnitudes
	logic signed [lpca_pkg::NumW-1:0] ap6, aq6;
	always_comb begin
		ap6 = np_s6[lpca_pkg::NumW-1] ? -np_s6 : np_s6;
		aq6 = nq_s6[lpca_pkg::NumW-1] ? -nq_s6 : nq_s6;
	end

	always_ff @(posedge clk) begin
		mp_s7   <= ap6[lpca_pkg::MagW-1:0];
		mq_s7   <= aq6[lpca_pkg::MagW-1:0];
		negp_s7 <= np_s6[lpca_pkg::NumW-1];
		negq_s7 <= nq_s6[lpca_pkg::NumW-1];
		den_s7  <= den_s6;
		par_s7  <= par_s6;
		pay_s7  <= pay_s6;
	end

	// divider entry: overflow check on the upper dividend bits
	lpca_pkg::carry_t car_in;
	always_comb begin
		car_in.pay = pay_s7;
		car_in.par = par_s7;
		car_in.den = den_s7;
		car_in.dp.ovf = {14'b0, mp_s7[69:27]} >= den_s7;
		car_in.dq.ovf = {14'b0, mq_s7[69:27]} >= den_s7;
		car_in.dp.rem = car_in.dp.ovf ? '0 : {15'b0, mp_s7[69:27]};
		car_in.dq.rem = car_in.dq.ovf ? '0 : {15'b0, mq_s7[69:27]};
		car_in.dp.low = {mp_s7[26:0], 14'b0};
		car_in.dq.low = {mq_s7[26:0], 14'b0};
		car_in.dp.quo = '0;
		car_in.dq.quo = '0;
		car_in.dp.neg = negp_s7;
		car_in.dq.neg = negq_s7;
	end

	always_ff @(posedge clk) begin
		car_s[0] <= car_in;
	end

	// divider stages: one quotient bit each
	for (genvar k = 1; k <= lpca_pkg::QBits; k++) begin : g_div
		always_ff @(posedge clk) begin
			car_s[k] <= lpca_pkg::carry_step(car_s[k-1]);
		end
	end

	// saturate parameters and decide in_front
	logic signed [lpca_pkg::ParW-1:0] pf, qf;
	always_comb begin
		pf = lpca_pkg::param_value(car_s[lpca_pkg::QBits].dp);
		qf = lpca_pkg::param_value(car_s[lpca_pkg::QBits].dq);
	end

	always_ff @(posedge clk) begin
		p_sp     <= pf;
		q_sp     <= qf;
		front_sp <= (pf < 42'sd256) && (qf < 42'sd256);
		par_sp   <= car_s[lpca_pkg::QBits].par;
		pay_sp   <= car_s[lpca_pkg::QBits].pay;
	end

	// midpoint products
	logic signed [lpca_pkg::DirW-1:0] up [3];
	logic signed [lpca_pkg::DirW-1:0] vp [3];
	logic signed [lpca_pkg::SumW-1:0] abp [3];
	always_comb begin
		up[0] = pay_sp.ux; up[1] = pay_sp.uy; up[2] = pay_sp.uz;
		vp[0] = pay_sp.vx; vp[1] = pay_sp.vy; vp[2] = pay_sp.vz;
		abp[0] = pay_sp.ab_x; abp[1] = pay_sp.ab_y; abp[2] = pay_sp.ab_z;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mu_sm[i] <= 58'(up[i]) * 58'(p_sp);
			mv_sm[i] <= 58'(vp[i]) * 58'(q_sp);
			ab_sm[i] <= 39'(abp[i]) <<< 14;
		end
		par_sm   <= par_sp;
		front_sm <= front_sp;
	end

	// sum, round half up, saturate
	logic signed [59:0] msum [3];
	logic signed [59:0] mrnd [3];
	logic signed [lpca_pkg::PosW-1:0] msat [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msum[i] = 60'(ab_sm[i]) + 60'(mu_sm[i]) + 60'(mv_sm[i]) + 60'sd16384;
			mrnd[i] = msum[i] >>> 15;
			if (mrnd[i] > 60'sd8388607) begin
				msat[i] = 24'sh7FFFFF;
			end else if (mrnd[i] < -60'sd8388608) begin
				msat[i] = 24'sh800000;
			end else begin
				msat[i] = mrnd[i][lpca_pkg::PosW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (par_sm) begin
			result_q <= '{mid_x: '0, mid_y: '0, mid_z: '0, in_front: 1'b0,
				parallel_error: 1'b1};
		end else begin
			result_q <= '{mid_x: msat[0], mid_y: msat[1], mid_z: msat[2],
				in_front: front_sm, parallel_error: 1'b0};
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// every accepted transaction comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ##(lpca_pkg::PipeLat) done)
		else $error("transaction lost in pipeline");

	// a result never appears without a transaction behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, lpca_pkg::PipeLat))
		else $error("result without transaction");

	// parallel lines give a zero midpoint and no in_front
	a_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.parallel_error) |->
		(result.mid_x == '0 && result.mid_y == '0 && result.mid_z == '0 && !result.in_front))
		else $error("parallel result not cleared");

	// finished division leaves a remainder below the divisor unless it overflowed
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_dv[lpca_pkg::QBits] && !car_s[lpca_pkg::QBits].par) |->
		((car_s[lpca_pkg::QBits].dp.ovf ||
			car_s[lpca_pkg::QBits].dp.rem < {1'b0, car_s[lpca_pkg::QBits].den}) &&
		(car_s[lpca_pkg::QBits].dq.ovf ||
			car_s[lpca_pkg::QBits].dq.rem < {1'b0, car_s[lpca_pkg::QBits].den})))
		else $error("divider remainder out of range");

endmodule

FILE: test/tb_line_pair_closest_approach.sv
// Self-checking testbench for the line-pair closest-approach pipeline.
module tb_line_pair_closest_approach;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PosW    = lpca_pkg::PosW;
	localparam int DirW    = lpca_pkg::DirW;
	localparam int ThrW    = lpca_pkg::ThrW;
	localparam int PipeLat = lpca_pkg::PipeLat;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lpca_pkg::item_t item = '0;
	logic done;
	lpca_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [ThrW-1:0] cfg_data = '0;

	logic [ThrW-1:0] threshold = lpca_pkg::ThrReset;
	lpca_pkg::result_t midpoint_q[$];
	int unsigned sent_cnt = 0;
	int unsigned got_cnt = 0;
	int unsigned parallel_cnt = 0;
	int unsigned front_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cfg_cnt = 0;
	bit idle_on = 1'b1;

	line_pair_closest_approach u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// solve one line parameter: (n * 2^14) / den, toward zero, clamped to 2^40
	function automatic longint solve_param(logic signed [127:0] n, logic [63:0] den);
		logic [127:0] m;
		logic [127:0] qt;
		m = n[127] ? -n : n;
		qt = (m << 14) / {64'd0, den};
		if (qt > (128'd1 << 40))
			qt = 128'd1 << 40;
		return n[127] ? -longint'(qt[63:0]) : longint'(qt[63:0]);
	endfunction

	// halve Q.22 sum into Q.8 with round half up, then clamp
	function automatic logic signed [PosW-1:0] round_mid(longint s);
		longint v;
		v = (s + (64'sd1 <<< 14)) >>> 15;
		if (v > 64'sd8388607)
			v = 64'sd8388607;
		if (v < -64'sd8388608)
			v = -64'sd8388608;
		return v[PosW-1:0];
	endfunction

	function automatic lpca_pkg::result_t predict_midpoint(lpca_pkg::item_t it);
		lpca_pkg::result_t r;
		longint a[3], b[3], u[3], v[3];
		longint cs, ud, vd, ac, om, p, q, s;
		logic [63:0] den;
		logic signed [127:0] np, nq;
		a = '{it.first_point_x, it.first_point_y, it.first_point_z};
		b = '{it.second_point_x, it.second_point_y, it.second_point_z};
		u = '{it.first_dir_x, it.first_dir_y, it.first_dir_z};
		v = '{it.second_dir_x, it.second_dir_y, it.second_dir_z};
		cs = 0; ud = 0; vd = 0;
		for (int i = 0; i < 3; i++) begin
			cs += u[i] * v[i];
			ud += u[i] * (b[i] - a[i]);
			vd += v[i] * (b[i] - a[i]);
		end
		ac = cs < 0 ? -cs : cs;
		om = (64'sd1 <<< 28) - ac;
		r = '0;
		if (om <= 0 || om < longint'(threshold)) begin
			r.parallel_error = 1'b1;
			return r;
		end
		den = om * ((64'sd1 <<< 28) + ac);
		np = (128'(ud) <<< 28) - 128'(cs) * 128'(vd);
		nq = 128'(cs) * 128'(ud) - (128'(vd) <<< 28);
		p = solve_param(np, den);
		q = solve_param(nq, den);
		for (int i = 0; i < 3; i++) begin
			s = (a[i] + b[i]) * 16384 + u[i] * p + v[i] * q;
			if (i == 0) r.mid_x = round_mid(s);
			else if (i == 1) r.mid_y = round_mid(s);
			else r.mid_z = round_mid(s);
		end
		r.in_front = (p < 256 && q < 256);
		return r;
	endfunction

	// record expectation for each accepted transaction
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			midpoint_q.push_back(predict_midpoint(item));
	end

	// compare each result against the oldest expectation
	always @(posedge clk) begin
		lpca_pkg::result_t e;
		if (arst_n && done) begin
			got_cnt++;
			if (midpoint_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result %p", $realtime, result);
			end else begin
				e = midpoint_q.pop_front();
				if (result.parallel_error) parallel_cnt++;
				if (result.in_front) front_cnt++;
				if (e.mid_x !== result.mid_x || e.mid_y !== result.mid_y ||
				    e.mid_z !== result.mid_z || e.in_front !== result.in_front ||
				    e.parallel_error !== result.parallel_error) begin
					err_cnt++;
					$display("%0t: mismatch expected %p actual %p", $realtime, e, result);
				end
			end
		end
	end

	// issue one transaction, then maybe idle for a burst
	task automatic send_pair(lpca_pkg::item_t it);
		logic b;
		item <= it;
		start <= 1'b1;
		do begin
			@(negedge clk) b = busy;
			@(posedge clk);
		end while (b);
		sent_cnt++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (midpoint_q.size() != 0) @(posedge clk);
		repeat (PipeLat + 4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [ThrW-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = val;
		cfg_cnt++;
	endtask

	// near-unit direction from a random vector, sometimes raw noise
	function automatic void rand_dir(output logic signed [DirW-1:0] d[3]);
		real x, y, z, n;
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 0; i < 3; i++) d[i] = DirW'($urandom);
			return;
		end
		x = real'($urandom_range(0, 2000)) - 1000.0;
		y = real'($urandom_range(0, 2000)) - 1000.0;
		z = real'($urandom_range(0, 2000)) - 1000.0;
		n = $sqrt(x * x + y * y + z * z);
		if (n < 1.0) begin x = 1.0; n = 1.0; end
		d[0] = DirW'($rtoi(16384.0 * x / n));
		d[1] = DirW'($rtoi(16384.0 * y / n));
		d[2] = DirW'($rtoi(16384.0 * z / n));
	endfunction

	function automatic logic signed [PosW-1:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return PosW'($urandom);
			1: return PosW'($signed($urandom_range(0, 8191)) - 4096);
			default: return PosW'($signed($urandom_range(0, 262143)) - 131072);
		endcase
	endfunction

	function automatic lpca_pkg::item_t rand_pair();
		lpca_pkg::item_t it;
		logic signed [DirW-1:0] du[3], dv[3];
		rand_dir(du);
		case ($urandom_range(0, 7))
			0: dv = du;
			1: begin dv[0] = -du[0]; dv[1] = -du[1]; dv[2] = -du[2]; end
			2: begin
				dv = du;
				dv[$urandom_range(0, 2)] += DirW'($signed($urandom_range(0, 64)) - 32);
			end
			default: rand_dir(dv);
		endcase
		it.first_point_x = rand_pos(); it.first_point_y = rand_pos();
		it.first_point_z = rand_pos();
		it.second_point_x = rand_pos(); it.second_point_y = rand_pos();
		it.second_point_z = rand_pos();
		{it.first_dir_x, it.first_dir_y, it.first_dir_z} = {du[0], du[1], du[2]};
		{it.second_dir_x, it.second_dir_y, it.second_dir_z} = {dv[0], dv[1], dv[2]};
		return it;
	endfunction

	function automatic lpca_pkg::item_t make_pair(int ax, int ay, int az, int ux, int uy,
		int uz, int bx, int by, int bz, int vx, int vy, int vz);
		lpca_pkg::item_t it;
		it = '{PosW'(ax), PosW'(ay), PosW'(az), DirW'(ux), DirW'(uy), DirW'(uz),
		       PosW'(bx), PosW'(by), PosW'(bz), DirW'(vx), DirW'(vy), DirW'(vz)};
		return it;
	endfunction

	// directed corners: axes, parallel, antiparallel, extremes, odd directions
	task automatic test_directed();
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 256, 256, 0, 0, 16384, 0));
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 5000, 0, 0, 0, 0, 16384));
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 0, 100, 0, 16384, 0, 0));
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 0, 100, 0, -16384, 0, 0));
		send_pair(make_pair(-8388608, -8388608, -8388608, -16384, 0, 0,
			8388607, 8388607, 8388607, 0, -16384, 0));
		send_pair(make_pair(8388607, 8388607, 8388607, 0, 0, 16384,
			8388607, 8388607, 8388607, 16384, 0, 0));
		send_pair(make_pair(-8388608, 0, 8388607, 11585, 11585, 0,
			8388607, 0, -8388608, 0, 11585, -11585));
		send_pair(make_pair(100, 200, 300, 0, 0, 0, 400, 500, 600, 0, 0, 0));
		send_pair(make_pair(100, 200, 300, -32768, 32767, -32768, 0, 0, 0, 32767, 0, 0));
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 0, 256, 0, 16383, 181, 0));
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 0, 256, 0, 16384, 1, 0));
		send_pair(make_pair(0, 0, 0, 16384, 0, 0, 0, 256, 0, 16380, 362, 0));
		send_pair(make_pair(-1, -1, -1, 0, 16384, 0, 1, 0, -1, 0, 0, -16384));
		send_pair(make_pair(8388607, -8388608, 0, 16384, 0, 0,
			-8388608, 8388607, 0, 0, 16384, 0));
		send_pair(make_pair(0, 0, 0, 9459, 9459, 9459, 1, 1, 1, 9459, -9459, 9459));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i == n - n / 5) idle_on = 1'b0;
			send_pair(rand_pair());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		write_threshold('0);
		test_directed();
		test_random(250);
		write_threshold(29'd268435456);
		test_directed();
		test_random(150);
		write_threshold(29'd200000);
		test_random(250);
		write_threshold(ThrW'($urandom_range(0, 268435456)));
		test_random(150);
		write_threshold(ThrW'($urandom));
		test_random(100);
		drain();
		$display("Sent %0d line pairs under %0d threshold writes; %0d results checked",
			sent_cnt, cfg_cnt, got_cnt);
		$display("Parallel results %0d, in-front results %0d, errors %0d",
			parallel_cnt, front_cnt, err_cnt);
		if (err_cnt == 0 && midpoint_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop for a hung pipeline
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
